// File: rtl/bsf_pkg.sv
// bsf_pkg: shared types and constants for the byte stuffing framer.
// Beat structs, register indexes and the per-item output plan.
// No dependencies.
package bsf_pkg;

    localparam int PlanDepth = 5;
    localparam int PlanCntW  = $clog2(PlanDepth + 1);
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic RegFlag   = 1'b0;
    localparam logic RegEscape = 1'b1;

    localparam logic [7:0] FlagReset   = 8'd36;
    localparam logic [7:0] EscapeReset = 8'd47;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_trailer;
        logic       last_out;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
    } cfg_t;

    typedef struct packed {
        out_beat_t [PlanDepth-1:0] beats;
        logic [PlanCntW-1:0]       count;
    } plan_t;

endpackage

// File: rtl/byte_stuff_framer_with_parity.sv
// Byte stuffing framer with XOR parity trailer. An accepted payload byte sits
// in an input register, is expanded into 1 to 5 output beats (opening flag,
// escape, data, closing flag, parity trailer) and these leave one per cycle
// from an output queue unless out_stall holds them. The output port sets the
// rate, and the next item is loaded in the cycle its predecessor's last beat
// is taken. Each result beat carries last_out on the final beat of its item.
// Registers: flag at 0x0, escape at 0x4; write them only while the framer is
// idle.
// Depends on bsf_pkg, bsf_regs, bsf_encode, bsf_emit.
module byte_stuff_framer_with_parity (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bsf_pkg::in_beat_t          in_beat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bsf_pkg::out_beat_t         out_beat,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsf_pkg::AddrW-1:0]  paddr,
    input  logic [bsf_pkg::DataW-1:0]  pwdata,
    output logic [bsf_pkg::DataW-1:0]  prdata,
    output logic                       pready
);

    bsf_pkg::cfg_t      cfg;
    bsf_pkg::plan_t     plan;
    bsf_pkg::in_beat_t  item_reg;
    logic               item_valid_reg;
    logic               inside_frame_reg;
    logic [7:0]         parity_reg;
    logic               inside_frame_next;
    logic [7:0]         parity_next;
    logic               can_load;
    logic               load;
    logic               in_take;

    assign pready   = 1'b1;
    assign load     = item_valid_reg && can_load;
    assign in_stall = item_valid_reg && !load;
    assign in_take  = in_valid && !in_stall;

    bsf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bsf_encode u_encode (
        .item              (item_reg),
        .cfg               (cfg),
        .inside_frame      (inside_frame_reg),
        .parity            (parity_reg),
        .plan              (plan),
        .inside_frame_next (inside_frame_next),
        .parity_next       (parity_next)
    );

    bsf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .plan      (plan),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            inside_frame_reg <= 1'b0;
            parity_reg       <= 8'd0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                item_valid_reg <= 1'b0;
            end
            if (load)
            begin
                inside_frame_reg <= inside_frame_next;
                parity_reg       <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_beat;
        end
    end

`ifndef SYNTHESIS
    a_trailer_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.is_trailer |-> out_beat.last_out)
        else $error("trailer beat without last_out");

    a_plan_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (plan.count != '0)
              && (plan.count <= bsf_pkg::PlanCntW'(bsf_pkg::PlanDepth)))
        else $error("plan beat count out of range");

    a_parity_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_frame_reg |-> (parity_reg == 8'd0))
        else $error("parity not cleared outside a frame");

    a_load_shows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded item produced no output beat");
`endif

endmodule

// File: rtl/bsf_regs.sv
// bsf_regs: APB register file holding the flag and escape values.
// Depends on bsf_pkg.
module bsf_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsf_pkg::AddrW-1:0]  paddr,
    input  logic [bsf_pkg::DataW-1:0]  pwdata,
    output logic [bsf_pkg::DataW-1:0]  prdata,
    output bsf_pkg::cfg_t              cfg
);

    logic [7:0] flag_reg;
    logic [7:0] escape_reg;
    logic       wr_en;
    logic       idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= bsf_pkg::FlagReset;
            escape_reg <= bsf_pkg::EscapeReset;
        end
        else if (wr_en)
        begin
            case (idx)
                bsf_pkg::RegFlag:   flag_reg   <= pwdata[7:0];
                bsf_pkg::RegEscape: escape_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bsf_pkg::RegFlag:   prdata = {{(bsf_pkg::DataW-8){1'b0}}, flag_reg};
            bsf_pkg::RegEscape: prdata = {{(bsf_pkg::DataW-8){1'b0}}, escape_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.flag_value   = flag_reg;
    assign cfg.escape_value = escape_reg;

endmodule

// File: rtl/bsf_encode.sv
// bsf_encode: turns one payload byte into its list of frame beats
// and computes the next frame state and running parity. Depends on bsf_pkg.
module bsf_encode (
    input  bsf_pkg::in_beat_t  item,
    input  bsf_pkg::cfg_t      cfg,
    input  logic               inside_frame,
    input  logic [7:0]         parity,
    output bsf_pkg::plan_t     plan,
    output logic               inside_frame_next,
    output logic [7:0]         parity_next
);

    logic [bsf_pkg::PlanCntW-1:0] k;
    logic [7:0]                   body_par;
    logic                         need_esc;

    assign need_esc = (item.data_byte == cfg.flag_value)
                   || (item.data_byte == cfg.escape_value);

    always_comb
    begin
        plan     = '0;
        k        = '0;
        body_par = inside_frame ? parity : 8'd0;
        if (!inside_frame)
        begin
            plan.beats[k] = '{out_byte: cfg.flag_value, is_trailer: 1'b0, last_out: 1'b0};
            body_par      = body_par ^ cfg.flag_value;
            k             = k + 1'b1;
        end
        if (need_esc)
        begin
            plan.beats[k] = '{out_byte: cfg.escape_value, is_trailer: 1'b0, last_out: 1'b0};
            body_par      = body_par ^ cfg.escape_value;
            k             = k + 1'b1;
        end
        plan.beats[k] = '{out_byte: item.data_byte, is_trailer: 1'b0, last_out: 1'b0};
        body_par      = body_par ^ item.data_byte;
        k             = k + 1'b1;
        if (item.end_of_payload)
        begin
            plan.beats[k] = '{out_byte: cfg.flag_value, is_trailer: 1'b0, last_out: 1'b0};
            body_par      = body_par ^ cfg.flag_value;
            k             = k + 1'b1;
            plan.beats[k] = '{out_byte: body_par, is_trailer: 1'b1, last_out: 1'b0};
            k             = k + 1'b1;
        end
        plan.beats[k - 1'b1].last_out = 1'b1;
        plan.count = k;
    end

    assign inside_frame_next = !item.end_of_payload;
    assign parity_next       = item.end_of_payload ? 8'd0 : body_par;

endmodule

// File: rtl/bsf_emit.sv
// bsf_emit: output queue that holds one item's beats and sends one per cycle
// while out_stall is low. The head entry is the registered output beat. Depends on bsf_pkg.
module bsf_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bsf_pkg::plan_t      plan,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_stall,
    output bsf_pkg::out_beat_t  out_beat
);

    bsf_pkg::out_beat_t [bsf_pkg::PlanDepth-1:0] q_reg;
    logic [bsf_pkg::PlanCntW-1:0]                cnt_reg;
    logic                                        pop;

    assign out_valid = (cnt_reg != '0);
    assign out_beat  = q_reg[0];
    assign pop       = out_valid && !out_stall;
    assign can_load  = (cnt_reg == '0)
                    || ((cnt_reg == bsf_pkg::PlanCntW'(1)) && !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= plan.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= plan.beats;
        end
        else if (pop)
        begin
            for (int i = 0; i < bsf_pkg::PlanDepth - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule

// File: verif/bsf_frame_checker.sv
`timescale 1ns / 1ps
// bsf_frame_checker: watches the payload, frame and register ports of the framer,
// predicts every frame beat, compares it with what leaves the block and checks
// register reads. Depends on bsf_pkg.
module bsf_frame_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  bsf_pkg::in_beat_t         in_beat,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  bsf_pkg::out_beat_t        out_beat,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bsf_pkg::AddrW-1:0] paddr,
    input  logic [bsf_pkg::DataW-1:0] pwdata,
    input  logic [bsf_pkg::DataW-1:0] prdata,
    input  logic                      pready,
    output int                        fail_count,
    output int                        pending
);

    bsf_pkg::cfg_t      regs;
    logic               frame_open;
    logic [7:0]         parity;
    bsf_pkg::out_beat_t frame_q[$];
    bsf_pkg::out_beat_t burst[bsf_pkg::PlanDepth];
    int                 burst_n;

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic add_beat(input logic [7:0] value, input logic trailer);
        burst[burst_n] = '{out_byte: value, is_trailer: trailer, last_out: 1'b0};
        burst_n++;
        if (!trailer)
            parity ^= value;
    endtask

    // expand one payload byte into its frame beats
    task automatic frame_payload(input bsf_pkg::in_beat_t b);
        burst_n = 0;
        if (!frame_open)
        begin
            parity = '0;
            add_beat(regs.flag_value, 1'b0);
            frame_open = 1'b1;
        end
        if (b.data_byte == regs.flag_value || b.data_byte == regs.escape_value)
            add_beat(regs.escape_value, 1'b0);
        add_beat(b.data_byte, 1'b0);
        if (b.end_of_payload)
        begin
            add_beat(regs.flag_value, 1'b0);
            add_beat(parity, 1'b1);
            frame_open = 1'b0;
            parity = '0;
        end
        burst[burst_n-1].last_out = 1'b1;
        for (int i = 0; i < burst_n; i++)
            frame_q.insert(frame_q.size(), burst[i]);
    endtask

    task automatic check_beat(input bsf_pkg::out_beat_t got);
        bsf_pkg::out_beat_t want;
        if (frame_q.size() == 0)
        begin
            note_fail($sformatf("unexpected beat: byte %h trailer %b last %b",
                                got.out_byte, got.is_trailer, got.last_out));
            return;
        end
        want = frame_q.pop_front();
        if (want.out_byte !== got.out_byte || want.is_trailer !== got.is_trailer ||
            want.last_out !== got.last_out)
            note_fail($sformatf("beat mismatch byte/trl/last: expected %h/%b/%b, got %h/%b/%b",
                                want.out_byte, want.is_trailer, want.last_out,
                                got.out_byte, got.is_trailer, got.last_out));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs       = '{flag_value: bsf_pkg::FlagReset, escape_value: bsf_pkg::EscapeReset};
            frame_open = 1'b0;
            parity     = '0;
            frame_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_beat(out_beat);
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[bsf_pkg::AddrW-1:2] == bsf_pkg::RegFlag)
                        regs.flag_value = pwdata[7:0];
                    else if (paddr[bsf_pkg::AddrW-1:2] == bsf_pkg::RegEscape)
                        regs.escape_value = pwdata[7:0];
                end
                else if (prdata[7:0] !== ((paddr[bsf_pkg::AddrW-1:2] == bsf_pkg::RegFlag) ?
                                          regs.flag_value : regs.escape_value))
                    note_fail($sformatf("register read at %h: expected %h, got %h", paddr,
                              (paddr[bsf_pkg::AddrW-1:2] == bsf_pkg::RegFlag) ?
                              regs.flag_value : regs.escape_value, prdata[7:0]));
            end
            if (in_valid && !in_stall)
                frame_payload(in_beat);
            pending = frame_q.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: drives payload bytes and register writes into byte_stuff_framer_with_parity
// with random gaps and backpressure; bsf_frame_checker judges the output beats.
// Depends on bsf_pkg, byte_stuff_framer_with_parity, bsf_frame_checker.
module tb;

    localparam int                        Limit    = 4000;
    localparam int                        NumItems = 300;
    localparam logic [bsf_pkg::AddrW-1:0] FlagAddr = bsf_pkg::AddrW'(4 * bsf_pkg::RegFlag);
    localparam logic [bsf_pkg::AddrW-1:0] EscAddr  = bsf_pkg::AddrW'(4 * bsf_pkg::RegEscape);

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    bsf_pkg::in_beat_t         in_beat = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    bsf_pkg::out_beat_t        out_beat;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [bsf_pkg::AddrW-1:0] paddr = '0;
    logic [bsf_pkg::DataW-1:0] pwdata = '0;
    logic [bsf_pkg::DataW-1:0] prdata;
    logic                      pready;

    int         fail_count;
    int         pending;
    int         stuck_cycles = 0;
    bit         quiet = 1'b0;
    logic [7:0] cur_flag = bsf_pkg::FlagReset;
    logic [7:0] cur_esc = bsf_pkg::EscapeReset;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    byte_stuff_framer_with_parity dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bsf_frame_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
        .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int wait_draw();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // called just after a falling edge; returns just after one
    task automatic push_byte(input logic [7:0] d, input logic eop);
        int gap;
        gap = wait_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_beat  <= '{data_byte: d, end_of_payload: eop};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [bsf_pkg::AddrW-1:0] addr,
                              input logic [7:0] value);
        in_valid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= wr;
        paddr    <= addr;
        pwdata   <= {24'($urandom_range(0, 16777215)), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr && addr == FlagAddr)
            cur_flag = value;
        else if (wr && addr == EscAddr)
            cur_esc = value;
    endtask

    task automatic set_regs(input logic [7:0] f, input logic [7:0] e);
        apb_access(1'b1, FlagAddr, f);
        apb_access(1'b1, EscAddr, e);
        apb_access(1'b0, FlagAddr, 8'h00);
        apb_access(1'b0, EscAddr, 8'h00);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return cur_flag;
            1: return cur_esc;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= Limit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // frame sink with random backpressure per beat
    initial
    begin
        int n;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            n = wait_draw();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int items;
        int len;
        logic [7:0] f;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, flag and escape in the body
        apb_access(1'b0, FlagAddr, 8'h00);
        apb_access(1'b0, EscAddr, 8'h00);
        push_byte(8'h24, 1'b0);
        push_byte(8'h2F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h41, 1'b1);
        push_byte(8'h24, 1'b1);
        wait_idle();

        // extreme register values
        set_regs(8'h00, 8'hFF);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7E, 1'b1);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // flag equals escape: one escape only
        set_regs(8'h55, 8'h55);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_idle();

        // register change with a frame open
        set_regs(8'h7E, 8'h7D);
        push_byte(8'h10, 1'b0);
        push_byte(8'h7E, 1'b0);
        wait_idle();
        apb_access(1'b1, FlagAddr, 8'h24);
        push_byte(8'h7D, 1'b0);
        wait_idle();
        apb_access(1'b1, EscAddr, 8'h24);
        push_byte(8'h24, 1'b1);
        wait_idle();

        items = 0;
        while (items < NumItems)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                case ($urandom_range(0, 5))
                    0: set_regs(8'h00, 8'hFF);
                    1: set_regs(8'hFF, 8'h00);
                    2:
                    begin
                        f = 8'($urandom_range(0, 255));
                        set_regs(f, f);
                    end
                    default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if (i == len / 2 && i > 0 && $urandom_range(0, 9) == 0)
                begin
                    wait_idle();
                    apb_access(1'b1, $urandom_range(0, 1) ? FlagAddr : EscAddr,
                               8'($urandom_range(0, 255)));
                end
                push_byte(pick_byte(), i == len - 1);
                items++;
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
